FILE: hw/rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  // Depth of the queue between front and back and of the result queue
  localparam int QUEUE_DEPTH = 2;

  localparam int TAB_STEP = 3;

  localparam logic [7:0] RESET_ATTR = 8'd7;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_TAB,
    OP_NEWLINE,
    OP_READ,
    OP_READ_NONE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK
  } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_fifo.sv
`default_nettype none

module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W:0]   rd_ptr_r, rd_ptr_nxt;
  logic             do_wr, do_rd;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[PTR_W] != rd_ptr_r[PTR_W]) &&
                   (wr_ptr_r[PTR_W-1:0] == rd_ptr_r[PTR_W-1:0]);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r[PTR_W-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r[PTR_W-1:0]] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_front.sv
`default_nettype none

module tcw_front #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
  input  wire logic          in_push,
  input  wire logic          in_func,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [10:0]   in_cell_index,
  output logic               in_full,
  input  wire logic          cmd_full,
  input  wire logic          clearing,
  output logic               cmd_push,
  output tcw_pkg::cmd_t      cmd
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int WIDE_W     = ADDR_W + 11;

  logic [WIDE_W-1:0] index_wide;
  logic              in_range;

  assign index_wide = {{ADDR_W{1'b0}}, in_cell_index};
  assign in_range   = index_wide < WIDE_W'(CELL_COUNT);

  // No beat is taken while the store is still being cleared after reset
  assign in_full  = cmd_full || clearing;
  assign cmd_push = in_push && !in_full;

  always_comb begin
    cmd.char_code  = in_char_code;
    cmd.cell_index = in_cell_index;
    if (in_func == tcw_pkg::FUNC_READ) begin
      cmd.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_READ_NONE;
    end else if (in_char_code == tcw_pkg::CHAR_TAB) begin
      cmd.op = tcw_pkg::OP_TAB;
    end else if (in_char_code == tcw_pkg::CHAR_LF || in_char_code == tcw_pkg::CHAR_CR) begin
      cmd.op = tcw_pkg::OP_NEWLINE;
    end else begin
      cmd.op = tcw_pkg::OP_PRINT;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_back.sv
`default_nettype none

module tcw_back #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  input  wire tcw_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output tcw_pkg::res_t      res,
  output logic               clearing
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(SCREEN_COLUMNS);
  localparam int WIDE_W     = ADDR_W + 11;

  localparam logic [ADDR_W-1:0] LAST_BASE  = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLUMNS);

  tcw_pkg::back_state_t state_r, state_nxt;

  logic [15:0]       screen_r [CELL_COUNT];
  logic [15:0]       rdata_r;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_we;

  logic [7:0]        attr_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;

  logic [COL_W:0]    col_adv;
  logic              wrap;
  logic [ADDR_W-1:0] pos_cur, pos_nxt;
  logic [WIDE_W-1:0] pos_cur_wide, pos_nxt_wide, index_wide;

  assign clearing = (state_r == tcw_pkg::ST_CLEAR);

  assign col_adv = (cmd.op == tcw_pkg::OP_TAB) ?
                   ({1'b0, col_r} + (COL_W + 1)'(tcw_pkg::TAB_STEP)) :
                   ({1'b0, col_r} + 1'b1);
  assign wrap    = (cmd.op == tcw_pkg::OP_NEWLINE) ||
                   (col_adv >= (COL_W + 1)'(SCREEN_COLUMNS));

  assign pos_cur      = base_r + ADDR_W'(col_r);
  assign pos_nxt      = base_nxt + ADDR_W'(col_nxt);
  assign pos_cur_wide = {11'b0, pos_cur};
  assign pos_nxt_wide = {11'b0, pos_nxt};
  assign index_wide   = {{ADDR_W{1'b0}}, cmd.cell_index};

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    base_nxt    = base_r;
    cnt_nxt     = cnt_r;
    wr_pend_nxt = 1'b0;
    wr_addr_nxt = wr_addr_r;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_r;
    mem_wdata   = rdata_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res         = '0;

    // The copy step of a scroll writes in the cycle after its read
    if (wr_pend_r) begin
      mem_we = 1'b1;
    end

    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = {tcw_pkg::RESET_ATTR, 8'h00};
        if (cnt_r == CELL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            tcw_pkg::OP_PRINT, tcw_pkg::OP_TAB, tcw_pkg::OP_NEWLINE: begin
              if (cmd.op == tcw_pkg::OP_PRINT) begin
                mem_we    = 1'b1;
                mem_waddr = pos_cur;
                mem_wdata = {attr_r, cmd.char_code};
              end
              if (wrap) begin
                col_nxt = '0;
                if (base_r == LAST_BASE) begin
                  cnt_nxt   = '0;
                  state_nxt = tcw_pkg::ST_COPY;
                end else begin
                  base_nxt = base_r + ROW_STRIDE;
                end
              end else begin
                col_nxt = col_adv[COL_W-1:0];
              end
              res_push       = 1'b1;
              res.cursor_pos = pos_nxt_wide[10:0];
            end
            tcw_pkg::OP_READ: begin
              mem_raddr = index_wide[ADDR_W-1:0];
              state_nxt = tcw_pkg::ST_READ;
            end
            default: begin
              res_push       = 1'b1;
              res.cursor_pos = pos_cur_wide[10:0];
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        res_push       = 1'b1;
        res.cursor_pos = pos_cur_wide[10:0];
        res.read_char  = rdata_r[7:0];
        res.read_attr  = rdata_r[15:8];
        state_nxt      = tcw_pkg::ST_IDLE;
      end

      tcw_pkg::ST_COPY: begin
        mem_raddr   = cnt_r + ROW_STRIDE;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = cnt_r;
        if (cnt_r == COPY_LAST) begin
          cnt_nxt   = LAST_BASE;
          state_nxt = tcw_pkg::ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcw_pkg::ST_BLANK: begin
        // Waits while the last copy write drains
        if (!wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r;
          mem_wdata = {attr_r, 8'h00};
          if (cnt_r == CELL_LAST) begin
            cnt_nxt   = '0;
            state_nxt = tcw_pkg::ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcw_pkg::ST_CLEAR;
      col_r     <= '0;
      base_r    <= '0;
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
      attr_r    <= tcw_pkg::RESET_ATTR;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      base_r    <= base_nxt;
      cnt_r     <= cnt_nxt;
      wr_pend_r <= wr_pend_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= screen_r[mem_raddr];
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < (COL_W + 1)'(SCREEN_COLUMNS))
    else $error("cursor column beyond the right edge");

  a_base_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= LAST_BASE)
    else $error("cursor row beyond the last row");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_copy_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> $past(state_r) == tcw_pkg::ST_COPY)
    else $error("scroll copy write without a preceding read");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> state_r == tcw_pkg::ST_IDLE && cmd_valid)
    else $error("command taken while the engine is busy");

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer_unit.sv
// Results: a put, tab or newline beat is answered from the IDLE state that takes it, a read
//   from the READ state after it; each needs a free result queue slot in the engine.
// Throughput: one put every cycle while the result queue has room, set by the engine; a read
//   holds the engine in its READ state, and a scroll stalls it (one store cell copied per cycle).
// Reset: synchronous, active low; afterwards a clearing pass fills the store with char 0,
//   attribute 7, and in_full stays high meanwhile.
`default_nettype none

module text_console_writer_unit #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [10:0] in_cell_index,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [10:0]      out_cursor_pos,
  output logic [7:0]       out_read_char,
  output logic [7:0]       out_read_attr
);

  localparam int CMD_W = $bits(tcw_pkg::cmd_t);
  localparam int RES_W = $bits(tcw_pkg::res_t);

  tcw_pkg::cmd_t  cmd_in, cmd_out;
  tcw_pkg::res_t  res_in, res_out;
  logic [CMD_W-1:0] cmd_q;
  logic [RES_W-1:0] res_q;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic res_push, res_full;
  logic clearing;

  tcw_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .in_push      (in_push),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .in_cell_index(in_cell_index),
    .in_full      (in_full),
    .cmd_full     (cmd_full),
    .clearing     (clearing),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  tcw_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(tcw_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_data(cmd_in),
    .rd_en  (cmd_pop),
    .rd_data(cmd_q),
    .full   (cmd_full),
    .empty  (cmd_empty)
  );

  assign cmd_out = tcw_pkg::cmd_t'(cmd_q);

  tcw_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd_out),
    .cmd_valid(!cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in),
    .clearing (clearing)
  );

  tcw_fifo #(
    .WIDTH(RES_W),
    .DEPTH(tcw_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res_in),
    .rd_en  (out_pop),
    .rd_data(res_q),
    .full   (res_full),
    .empty  (out_empty)
  );

  assign res_out        = tcw_pkg::res_t'(res_q);
  assign out_cursor_pos = res_out.cursor_pos;
  assign out_read_char  = res_out.read_char;
  assign out_read_attr  = res_out.read_attr;

endmodule

`default_nettype wire

FILE: sim/text_console_writer_unit_tb.sv
`timescale 1ns / 100ps

module text_console_writer_unit_tb;

  localparam int COLS = tcw_pkg::DEF_SCREEN_COLUMNS;
  localparam int ROWS = tcw_pkg::DEF_SCREEN_ROWS;
  localparam int CELLS = COLS * ROWS;
  // A scroll may still be walking the store after its beat has been reported.
  localparam int SETTLE_CYCLES = CELLS + 16;
  localparam int PHASE_ITEMS = 190;

  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_func = tcw_pkg::FUNC_PUT;
  logic [7:0]  in_char_code = 8'h00;
  logic [10:0] in_cell_index = 11'd0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [10:0] out_cursor_pos;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attr;

  text_console_writer_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_func       (in_func),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_cursor_pos(out_cursor_pos),
    .out_read_char (out_read_char),
    .out_read_attr (out_read_attr)
  );

  always #5 clk = ~clk;

  // Shadow of the console: cell store, cursor and attribute register.
  logic [15:0]  screen_mem [CELLS];
  int           cur_col = 0;
  int           cur_row = 0;
  logic [7:0]   text_attr = tcw_pkg::RESET_ATTR;

  stream_item_t          stream_items[$];
  tcw_pkg::res_t         console_replies[$];
  stream_item_t          drv_item = '0;
  int unsigned  items_sent = 0;
  int unsigned  items_taken = 0;
  int unsigned  fault_count = 0;
  int           push_hold = 0;
  int           pop_hold = 0;
  bit           calm = 1'b0;

  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int n = 0; n < CELLS - COLS; n++)
        screen_mem[n] = screen_mem[n + COLS];
      for (int n = CELLS - COLS; n < CELLS; n++)
        screen_mem[n] = {text_attr, 8'h00};
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic tcw_pkg::res_t console_apply(stream_item_t it);
    tcw_pkg::res_t r;
    r = '0;
    if (it.func == tcw_pkg::FUNC_PUT) begin
      if (it.char_code == tcw_pkg::CHAR_TAB) begin
        cur_col += tcw_pkg::TAB_STEP;
        if (cur_col >= COLS) line_feed();
      end else if (it.char_code == tcw_pkg::CHAR_LF || it.char_code == tcw_pkg::CHAR_CR) begin
        line_feed();
      end else begin
        screen_mem[cur_row * COLS + cur_col] = {text_attr, it.char_code};
        cur_col++;
        if (cur_col >= COLS) line_feed();
      end
    end else if (it.cell_index < CELLS) begin
      r.read_char = screen_mem[it.cell_index][7:0];
      r.read_attr = screen_mem[it.cell_index][15:8];
    end
    r.cursor_pos = 11'(cur_row * COLS + cur_col);
    return r;
  endfunction

  function automatic stream_item_t mk(logic f, logic [7:0] c, logic [10:0] i);
    stream_item_t it;
    it.func = f;
    it.char_code = c;
    it.cell_index = i;
    return it;
  endfunction

  function automatic stream_item_t random_item();
    stream_item_t it;
    int unsigned  k;
    k = $urandom_range(0, 99);
    it = mk(tcw_pkg::FUNC_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
    if (k < 28) begin
      it.func = tcw_pkg::FUNC_READ;
      if (k < 3)
        it.cell_index = 11'($urandom_range(CELLS, 2047));
      else if (k < 16)
        it.cell_index = 11'($urandom_range(CELLS - 5 * COLS, CELLS - 1));
      else
        it.cell_index = 11'($urandom_range(0, CELLS - 1));
    end else if (k < 38) begin
      it.char_code = tcw_pkg::CHAR_TAB;
    end else if (k < 48) begin
      it.char_code = k[0] ? tcw_pkg::CHAR_LF : tcw_pkg::CHAR_CR;
    end
    return it;
  endfunction

  task automatic queue_item(stream_item_t it);
    stream_items.push_back(it);
    items_sent++;
  endtask

  task automatic settle();
    while (items_taken != items_sent || console_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(logic [7:0] a);
    cfg_wdata <= a;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_attr = a;
  endtask

  // Driver: offers the next pending beat, holding it until it is taken.
  always @(posedge clk) begin
    logic nxt_push;
    nxt_push = in_push;
    if (rst_n) begin
      if (in_push && !in_full) begin
        console_replies.push_back(console_apply(drv_item));
        items_taken++;
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (push_hold > 0) begin
          push_hold--;
        end else if (stream_items.size() > 0) begin
          if (!calm && $urandom_range(0, 3) == 0) begin
            push_hold = $urandom_range(0, 2);
          end else begin
            drv_item = stream_items.pop_front();
            nxt_push = 1'b1;
          end
        end
      end
    end
    in_push <= nxt_push;
    in_func <= drv_item.func;
    in_char_code <= drv_item.char_code;
    in_cell_index <= drv_item.cell_index;
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    tcw_pkg::res_t want;
    logic nxt_pop;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (console_replies.size() == 0) begin
          $error("result beat with nothing expected, cursor_pos %0d", out_cursor_pos);
          fault_count++;
        end else begin
          want = console_replies.pop_front();
          if (out_cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, out_cursor_pos);
            fault_count++;
          end
          if (out_read_char !== want.read_char) begin
            $error("read_char: expected %0h, got %0h", want.read_char, out_read_char);
            fault_count++;
          end
          if (out_read_attr !== want.read_attr) begin
            $error("read_attr: expected %0h, got %0h", want.read_attr, out_read_attr);
            fault_count++;
          end
        end
      end
      if (pop_hold > 0) begin
        pop_hold--;
        nxt_pop = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pop_hold = $urandom_range(0, 2);
        nxt_pop = 1'b0;
      end else begin
        nxt_pop = 1'b1;
      end
      out_pop <= nxt_pop;
    end
  end

  initial begin
    logic [7:0] attr_plan [5];
    for (int n = 0; n < CELLS; n++) screen_mem[n] = {tcw_pkg::RESET_ATTR, 8'h00};
    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = 8'($urandom_range(1, 254));
    attr_plan[3] = 8'($urandom_range(1, 254));
    attr_plan[4] = 8'($urandom_range(0, 255));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats run with the attribute left at its reset value.
    queue_item(mk(tcw_pkg::FUNC_PUT, 8'h00, 11'd0));
    queue_item(mk(tcw_pkg::FUNC_PUT, 8'hFF, 11'd0));
    queue_item(mk(tcw_pkg::FUNC_PUT, 8'h41, 11'd0));
    queue_item(mk(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_TAB, 11'd0));
    queue_item(mk(tcw_pkg::FUNC_PUT, 8'h42, 11'd0));
    queue_item(mk(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_LF, 11'd0));
    queue_item(mk(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_CR, 11'd0));
    queue_item(mk(tcw_pkg::FUNC_READ, 8'h00, 11'd0));
    queue_item(mk(tcw_pkg::FUNC_READ, 8'h00, 11'd1));
    queue_item(mk(tcw_pkg::FUNC_READ, 8'h00, 11'd2));
    queue_item(mk(tcw_pkg::FUNC_READ, 8'h00, 11'd6));
    queue_item(mk(tcw_pkg::FUNC_READ, 8'h00, 11'(CELLS - 1)));
    queue_item(mk(tcw_pkg::FUNC_READ, 8'h00, 11'(CELLS)));
    queue_item(mk(tcw_pkg::FUNC_READ, 8'hFF, 11'h7FF));
    queue_item(mk(tcw_pkg::FUNC_PUT, 8'h7E, 11'h7FF));
    queue_item(mk(tcw_pkg::FUNC_READ, 8'h09, 11'(2 * COLS)));

    for (int p = 0; p < 5; p++) begin
      settle();
      write_attr(attr_plan[p]);
      if (p == 4) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) queue_item(random_item());
    end
    settle();

    if (fault_count == 0 && console_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
